FILE: src/gcvr_pkg.sv
// gcvr_pkg: shared types, constants and the sine table for the velocity resolver
// depends on nothing; imported by every module under src
package gcvr_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned TRIG_W = 14;
  localparam int unsigned VEL_W = 16;
  localparam int unsigned NUM_LANES = 6;

  localparam int unsigned FULL_TURN = 36000;
  localparam int unsigned HALF_TURN = 18000;
  localparam int unsigned QUARTER_TURN = 9000;
  localparam int unsigned ANG_W = 17;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned N_W = PHASE_W + IDX_W + 1;
  localparam int unsigned RECIP_SHIFT = 46;
  localparam int unsigned RECIP_W = 31;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + 64'd35999) / 64'd36000;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  localparam longint unsigned HALF_PI_Q31 = 64'd3373259426;
  localparam longint unsigned ONE_Q31 = 64'd2147483648;

  // lane order of the angle indexes
  typedef enum logic [2:0] {
    LANE_SR = 3'd0,
    LANE_CR = 3'd1,
    LANE_SP = 3'd2,
    LANE_CP = 3'd3,
    LANE_SY = 3'd4,
    LANE_CY = 3'd5
  } lane_e;

  // order of the rate/velocity words carried with an item
  typedef enum logic [2:0] {
    VEL_LX = 3'd0,
    VEL_LY = 3'd1,
    VEL_LZ = 3'd2,
    VEL_WR = 3'd3,
    VEL_WP = 3'd4,
    VEL_WY = 3'd5
  } vel_e;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef trig_t sine_tab_t [SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [NUM_LANES-1:0][IDX_W-1:0] idx;
    logic [NUM_LANES-1:0][VEL_W-1:0] vel;
  } item_t;

  function automatic longint unsigned div_step(input longint unsigned p, input int n,
                                               input bit want_cos);
    longint unsigned res;
    res = 64'd0;
    if (want_cos) begin
      case (n)
        1: res = p / 64'd2;
        2: res = p / 64'd12;
        3: res = p / 64'd30;
        4: res = p / 64'd56;
        5: res = p / 64'd90;
        6: res = p / 64'd132;
        7: res = p / 64'd182;
        default: res = p / 64'd240;
      endcase
    end else begin
      case (n)
        1: res = p / 64'd6;
        2: res = p / 64'd20;
        3: res = p / 64'd42;
        4: res = p / 64'd72;
        5: res = p / 64'd110;
        6: res = p / 64'd156;
        7: res = p / 64'd210;
        default: res = p / 64'd272;
      endcase
    end
    return res;
  endfunction

  function automatic longint unsigned series_q31(input longint unsigned t, input bit want_cos);
    longint unsigned t2;
    longint unsigned acc;
    longint unsigned term;
    longint unsigned prod;
    t2 = (t * t) >> 31;
    acc = want_cos ? ONE_Q31 : t;
    term = acc;
    for (int n = 1; n <= 8; n++) begin
      prod = (term * t2) >> 31;
      term = div_step(prod, n, want_cos);
      if ((n % 2) == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned q;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned mag;
    longint unsigned v;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q = 64'(4 * k);
      quad = q / SINE_TABLE_DEPTH;
      r = q % SINE_TABLE_DEPTH;
      t = (r * HALF_PI_Q31 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      mag = series_q31(t, quad[0]);
      v = (mag + (64'd1 << 18)) >> 19;
      tab[k] = (quad >= 64'd2) ? -TRIG_W'(v) : TRIG_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // round to nearest, ties up, then clamp to 16 bits
  function automatic logic [15:0] round_sat(input logic signed [63:0] x,
                                            input int unsigned sh);
    logic signed [63:0] r;
    r = (x + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[15:0];
  endfunction

endpackage

FILE: src/gimbal_camera_velocity_resolver_core.sv
// gimbal_camera_velocity_resolver_core: top level of the gimbal velocity resolver
// depends on gcvr_pkg, gcvr_front, gcvr_queue, gcvr_back
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_ready_o | lin_*, ang_*, mount_roll/pitch/yaw
//   out     | output    | out_valid_o/out_ready_i | body_v*, mount_*_rate
//
// one word per cycle while out_ready_i holds high; out_valid_o rises once the word has
// passed the front index register, a queue slot and eight arithmetic stages in the back
// reset clears the queue and all valid bits; no table clearing is needed
// an output stall freezes the back; the queue of 4 words then fills and drops in_ready_o
module gimbal_camera_velocity_resolver_core import gcvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] lin_x_i,
  input  logic [15:0] lin_y_i,
  input  logic [15:0] lin_z_i,
  input  logic [15:0] ang_roll_i,
  input  logic [15:0] ang_pitch_i,
  input  logic [15:0] ang_yaw_i,
  input  logic [15:0] mount_roll_i,
  input  logic [15:0] mount_pitch_i,
  input  logic [15:0] mount_yaw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] body_vx_o,
  output logic [15:0] body_vy_o,
  output logic [15:0] body_vz_o,
  output logic [15:0] mount_roll_rate_o,
  output logic [15:0] mount_pitch_rate_o,
  output logic [15:0] mount_yaw_rate_o
);

  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             head;
  logic              empty;
  logic [QCNT_W-1:0] q_count;

  gcvr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .lin_x_i       (lin_x_i),
    .lin_y_i       (lin_y_i),
    .lin_z_i       (lin_z_i),
    .ang_roll_i    (ang_roll_i),
    .ang_pitch_i   (ang_pitch_i),
    .ang_yaw_i     (ang_yaw_i),
    .mount_roll_i  (mount_roll_i),
    .mount_pitch_i (mount_pitch_i),
    .mount_yaw_i   (mount_yaw_i),
    .q_count_i     (q_count),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  gcvr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .count_o     (q_count)
  );

  gcvr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .body_vx_o          (body_vx_o),
    .body_vy_o          (body_vy_o),
    .body_vz_o          (body_vz_o),
    .mount_roll_rate_o  (mount_roll_rate_o),
    .mount_pitch_rate_o (mount_pitch_rate_o),
    .mount_yaw_rate_o   (mount_yaw_rate_o)
  );

endmodule

FILE: src/gcvr_front.sv
// gcvr_front: accepts items and turns the three gimbal angles into sine table indexes
// depends on gcvr_pkg; feeds gcvr_queue
module gcvr_front import gcvr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [VEL_W-1:0]              lin_x_i,
  input  logic [VEL_W-1:0]              lin_y_i,
  input  logic [VEL_W-1:0]              lin_z_i,
  input  logic [VEL_W-1:0]              ang_roll_i,
  input  logic [VEL_W-1:0]              ang_pitch_i,
  input  logic [VEL_W-1:0]              ang_yaw_i,
  input  logic [15:0]                   mount_roll_i,
  input  logic [15:0]                   mount_pitch_i,
  input  logic [15:0]                   mount_yaw_i,
  input  logic [QCNT_W-1:0]             q_count_i,
  output logic                          push_o,
  output item_t                         push_item_o
);

  logic                               v1_q;
  logic [NUM_LANES-1:0][N_W-1:0]      n1_q;
  logic [NUM_LANES-1:0][VEL_W-1:0]    vel1_q;
  logic [NUM_LANES-1:0][N_W-1:0]      n_d;
  logic                               accept;

  // angle offset by a quarter turn for cosine, none for sine, reduced to one turn
  function automatic logic [N_W-1:0] angle_to_n(input logic [15:0] a, input bit is_sin);
    logic signed [ANG_W+1:0] xs;
    logic [ANG_W-1:0]        x;
    logic [PHASE_W-1:0]      phase;
    xs = (ANG_W+2)'($signed(a)) +
         (is_sin ? (ANG_W+2)'(2 * FULL_TURN) : (ANG_W+2)'(2 * FULL_TURN + QUARTER_TURN));
    x = xs[ANG_W-1:0];
    if (x >= ANG_W'(3 * FULL_TURN)) phase = PHASE_W'(x - ANG_W'(3 * FULL_TURN));
    else if (x >= ANG_W'(2 * FULL_TURN)) phase = PHASE_W'(x - ANG_W'(2 * FULL_TURN));
    else if (x >= ANG_W'(FULL_TURN)) phase = PHASE_W'(x - ANG_W'(FULL_TURN));
    else phase = PHASE_W'(x);
    return N_W'(phase) * N_W'(SINE_TABLE_DEPTH) + N_W'(HALF_TURN);
  endfunction

  assign in_ready_o = (QCNT_W'(q_count_i) + QCNT_W'(v1_q)) < QCNT_W'(QDEPTH);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    n_d[LANE_SR] = angle_to_n(mount_roll_i, 1'b1);
    n_d[LANE_CR] = angle_to_n(mount_roll_i, 1'b0);
    n_d[LANE_SP] = angle_to_n(mount_pitch_i, 1'b1);
    n_d[LANE_CP] = angle_to_n(mount_pitch_i, 1'b0);
    n_d[LANE_SY] = angle_to_n(mount_yaw_i, 1'b1);
    n_d[LANE_CY] = angle_to_n(mount_yaw_i, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n1_q <= n_d;
      vel1_q[VEL_LX] <= lin_x_i;
      vel1_q[VEL_LY] <= lin_y_i;
      vel1_q[VEL_LZ] <= lin_z_i;
      vel1_q[VEL_WR] <= ang_roll_i;
      vel1_q[VEL_WP] <= ang_pitch_i;
      vel1_q[VEL_WY] <= ang_yaw_i;
    end
  end

  // exact floor division by a full turn through the reciprocal
  always_comb begin
    logic [N_W+RECIP_W-1:0] prod;
    push_item_o.vel = vel1_q;
    for (int i = 0; i < NUM_LANES; i++) begin
      prod = (N_W+RECIP_W)'(n1_q[i]) * (N_W+RECIP_W)'(RECIP_MUL);
      push_item_o.idx[i] = prod[RECIP_SHIFT +: IDX_W];
    end
  end

  assign push_o = v1_q;

endmodule

FILE: src/gcvr_queue.sv
// gcvr_queue: short word queue between the index front and the arithmetic back
// depends on gcvr_pkg
module gcvr_queue import gcvr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  item_t             push_item_i,
  input  logic              pop_i,
  output item_t             head_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d;
  logic [QPTR_W-1:0]  rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop = pop_i && !empty_o;
  assign head_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/gcvr_back.sv
// gcvr_back: sine lookup, rotation products, rounding and saturation
// depends on gcvr_pkg; pulls words from gcvr_queue
module gcvr_back import gcvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] body_vx_o,
  output logic [15:0] body_vy_o,
  output logic [15:0] body_vz_o,
  output logic [15:0] mount_roll_rate_o,
  output logic [15:0] mount_pitch_rate_o,
  output logic [15:0] mount_yaw_rate_o
);

  localparam int unsigned P_W = TRIG_W + VEL_W;
  localparam int unsigned S_W = P_W + 1;
  localparam int unsigned Q_W = TRIG_W + S_W;
  localparam int unsigned Y_W = Q_W + 1;
  localparam int unsigned R_W = TRIG_W + Y_W;
  localparam int unsigned X_W = R_W + 1;
  localparam int unsigned NSTG = 8;

  logic [NSTG-1:0] v_q;
  logic            en;

  // stage 1
  trig_t                       trig1_q [NUM_LANES];
  logic signed [VEL_W-1:0]     vel1_q [NUM_LANES];
  // stage 2
  logic signed [P_W-1:0] cpvz2_q, spvy2_q, cpvy2_q, spvz2_q;
  logic signed [P_W-1:0] cpwy2_q, spwp2_q, cpwp2_q, spwy2_q, crvx2_q, srvx2_q;
  trig_t                 cr2_q, sr2_q, cy2_q, sy2_q;
  logic [VEL_W-1:0]      wr2_q;
  // stage 3
  logic signed [S_W-1:0] a3_q, c3_q, rs3_q, m3_q;
  logic signed [P_W-1:0] crvx3_q, srvx3_q;
  trig_t                 cr3_q, sr3_q, cy3_q, sy3_q;
  logic [VEL_W-1:0]      wr3_q;
  // stage 4
  logic signed [Q_W-1:0] crc4_q, src4_q, crm4_q, cya4_q, sya4_q;
  logic signed [P_W-1:0] crvx4_q, srvx4_q;
  logic signed [S_W-1:0] rs4_q;
  trig_t                 cy4_q, sy4_q;
  logic [VEL_W-1:0]      wr4_q;
  // stage 5
  logic signed [Y_W-1:0] y5_q, z5_q;
  logic signed [Q_W-1:0] cya5_q, sya5_q, crm5_q;
  logic signed [S_W-1:0] rs5_q;
  trig_t                 cy5_q, sy5_q;
  logic [VEL_W-1:0]      wr5_q;
  // stage 6
  logic signed [R_W-1:0] syy6_q, cyy6_q;
  logic signed [Q_W-1:0] cya6_q, sya6_q, crm6_q;
  logic signed [Y_W-1:0] z6_q;
  logic signed [S_W-1:0] rs6_q;
  logic [VEL_W-1:0]      wr6_q;
  // stage 7
  logic signed [X_W-1:0] x7_q, y7_q;
  logic signed [Y_W-1:0] z7_q;
  logic signed [Q_W-1:0] crm7_q;
  logic signed [S_W-1:0] rs7_q;
  logic [VEL_W-1:0]      wr7_q;
  // output word
  logic [15:0] vx_q, vy_q, vz_q, rr_q, pr_q, yr_q;

  assign en = !v_q[NSTG-1] || out_ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        trig1_q[i] <= SINE_TAB[head_i.idx[i]];
        vel1_q[i] <= $signed(head_i.vel[i]);
      end

      cpvz2_q <= trig1_q[LANE_CP] * vel1_q[VEL_LZ];
      spvy2_q <= trig1_q[LANE_SP] * vel1_q[VEL_LY];
      cpvy2_q <= trig1_q[LANE_CP] * vel1_q[VEL_LY];
      spvz2_q <= trig1_q[LANE_SP] * vel1_q[VEL_LZ];
      cpwy2_q <= trig1_q[LANE_CP] * vel1_q[VEL_WY];
      spwp2_q <= trig1_q[LANE_SP] * vel1_q[VEL_WP];
      cpwp2_q <= trig1_q[LANE_CP] * vel1_q[VEL_WP];
      spwy2_q <= trig1_q[LANE_SP] * vel1_q[VEL_WY];
      crvx2_q <= trig1_q[LANE_CR] * vel1_q[VEL_LX];
      srvx2_q <= trig1_q[LANE_SR] * vel1_q[VEL_LX];
      cr2_q <= trig1_q[LANE_CR];
      sr2_q <= trig1_q[LANE_SR];
      cy2_q <= trig1_q[LANE_CY];
      sy2_q <= trig1_q[LANE_SY];
      wr2_q <= vel1_q[VEL_WR];

      a3_q <= S_W'(cpvz2_q) + S_W'(spvy2_q);
      c3_q <= S_W'(cpvy2_q) - S_W'(spvz2_q);
      rs3_q <= S_W'(cpwy2_q) + S_W'(spwp2_q);
      m3_q <= S_W'(cpwp2_q) - S_W'(spwy2_q);
      crvx3_q <= crvx2_q;
      srvx3_q <= srvx2_q;
      cr3_q <= cr2_q;
      sr3_q <= sr2_q;
      cy3_q <= cy2_q;
      sy3_q <= sy2_q;
      wr3_q <= wr2_q;

      crc4_q <= cr3_q * c3_q;
      src4_q <= sr3_q * c3_q;
      crm4_q <= cr3_q * m3_q;
      cya4_q <= cy3_q * a3_q;
      sya4_q <= sy3_q * a3_q;
      crvx4_q <= crvx3_q;
      srvx4_q <= srvx3_q;
      rs4_q <= rs3_q;
      cy4_q <= cy3_q;
      sy4_q <= sy3_q;
      wr4_q <= wr3_q;

      y5_q <= (Y_W'(crvx4_q) <<< 12) - Y_W'(src4_q);
      z5_q <= (Y_W'(srvx4_q) <<< 12) + Y_W'(crc4_q);
      cya5_q <= cya4_q;
      sya5_q <= sya4_q;
      crm5_q <= crm4_q;
      rs5_q <= rs4_q;
      cy5_q <= cy4_q;
      sy5_q <= sy4_q;
      wr5_q <= wr4_q;

      syy6_q <= sy5_q * y5_q;
      cyy6_q <= cy5_q * y5_q;
      cya6_q <= cya5_q;
      sya6_q <= sya5_q;
      crm6_q <= crm5_q;
      z6_q <= z5_q;
      rs6_q <= rs5_q;
      wr6_q <= wr5_q;

      x7_q <= (X_W'(cya6_q) <<< 12) - X_W'(syy6_q);
      y7_q <= (X_W'(sya6_q) <<< 12) + X_W'(cyy6_q);
      z7_q <= z6_q;
      crm7_q <= crm6_q;
      rs7_q <= rs6_q;
      wr7_q <= wr6_q;

      vx_q <= round_sat(64'(x7_q), 36);
      vy_q <= round_sat(64'(y7_q), 36);
      vz_q <= round_sat(-64'(z7_q), 24);
      rr_q <= round_sat(64'(rs7_q), 12);
      pr_q <= wr7_q;
      yr_q <= round_sat(64'(crm7_q), 24);
    end
  end

  assign out_valid_o = v_q[NSTG-1];
  assign body_vx_o = vx_q;
  assign body_vy_o = vy_q;
  assign body_vz_o = vz_q;
  assign mount_roll_rate_o = rr_q;
  assign mount_pitch_rate_o = pr_q;
  assign mount_yaw_rate_o = yr_q;

endmodule

FILE: test/tb_top.sv
// tb_top: testbench for gimbal_camera_velocity_resolver_core, with a sine-table predictor
// depends on gcvr_pkg (table depth only) and the core under src
`timescale 1ns / 1ps

module tb_top;
  import gcvr_pkg::*;

  typedef struct {
    logic [15:0] vx, vy, vz, roll_spin, pitch_spin, yaw_spin;
  } motion_t;

  class resolver_board;
    longint trig_lut[SINE_TABLE_DEPTH];
    motion_t pending[$];
    int unsigned errors;

    function new();
      longint unsigned q, quad, r, t, t2, acc, term, dv, mag;
      errors = 0;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
        q = 4 * k;
        quad = q / SINE_TABLE_DEPTH;
        r = q % SINE_TABLE_DEPTH;
        t = (r * 64'd3373259426 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
        t2 = (t * t) >> 31;
        acc = quad[0] ? 64'd2147483648 : t;
        term = acc;
        for (int n = 1; n <= 8; n++) begin
          dv = quad[0] ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
          term = ((term * t2) >> 31) / dv;
          if (n % 2) acc -= term;
          else acc += term;
        end
        mag = (acc + (64'd1 << 18)) >> 19;
        trig_lut[k] = (quad >= 2) ? -longint'(mag) : longint'(mag);
      end
    endfunction

    // argument already carries the quarter-turn offset for sine
    function longint trig_at(longint a);
      longint phase, idx;
      phase = (a + 72000 + 9000) % 36000;
      idx = (phase * SINE_TABLE_DEPTH + 18000) / 36000;
      if (idx >= SINE_TABLE_DEPTH) idx = 0;
      return trig_lut[idx];
    endfunction

    function logic [15:0] round_clamp(longint x, int sh);
      longint v;
      v = (x + (longint'(1) << (sh - 1))) >>> sh;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_word(logic [15:0] w[9]);
      longint vx, vy, vz, wr, wp, wy, sr, cr, sp, cp, sy, cy, a, c, y3, z3;
      motion_t m;
      vx = $signed(w[0]); vy = $signed(w[1]); vz = $signed(w[2]);
      wr = $signed(w[3]); wp = $signed(w[4]); wy = $signed(w[5]);
      sr = trig_at(longint'($signed(w[6])) - 9000); cr = trig_at($signed(w[6]));
      sp = trig_at(longint'($signed(w[7])) - 9000); cp = trig_at($signed(w[7]));
      sy = trig_at(longint'($signed(w[8])) - 9000); cy = trig_at($signed(w[8]));
      a = cp * vz + sp * vy;
      c = cp * vy - sp * vz;
      y3 = cr * vx * 4096 - sr * c;
      z3 = sr * vx * 4096 + cr * c;
      m.vx = round_clamp(cy * a * 4096 - sy * y3, 36);
      m.vy = round_clamp(sy * a * 4096 + cy * y3, 36);
      m.vz = round_clamp(-z3, 24);
      m.roll_spin = round_clamp(cp * wy + sp * wp, 12);
      m.pitch_spin = w[3];
      m.yaw_spin = round_clamp(cr * (cp * wp - sp * wy), 24);
      pending.push_back(m);
    endfunction

    function void check_word(motion_t got);
      motion_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.vx !== e.vx) begin
        $error("body_vx exp %h got %h", e.vx, got.vx); errors++;
      end
      if (got.vy !== e.vy) begin
        $error("body_vy exp %h got %h", e.vy, got.vy); errors++;
      end
      if (got.vz !== e.vz) begin
        $error("body_vz exp %h got %h", e.vz, got.vz); errors++;
      end
      if (got.roll_spin !== e.roll_spin) begin
        $error("mount_roll_rate exp %h got %h", e.roll_spin, got.roll_spin); errors++;
      end
      if (got.pitch_spin !== e.pitch_spin) begin
        $error("mount_pitch_rate exp %h got %h", e.pitch_spin, got.pitch_spin); errors++;
      end
      if (got.yaw_spin !== e.yaw_spin) begin
        $error("mount_yaw_rate exp %h got %h", e.yaw_spin, got.yaw_spin); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [15:0] w_in[9];
  logic in_ready_o, out_valid_o;
  logic [15:0] body_vx_o, body_vy_o, body_vz_o;
  logic [15:0] mount_roll_rate_o, mount_pitch_rate_o, mount_yaw_rate_o;
  resolver_board board = new();
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  initial foreach (w_in[i]) w_in[i] = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  gimbal_camera_velocity_resolver_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .lin_x_i(w_in[0]), .lin_y_i(w_in[1]), .lin_z_i(w_in[2]),
    .ang_roll_i(w_in[3]), .ang_pitch_i(w_in[4]), .ang_yaw_i(w_in[5]),
    .mount_roll_i(w_in[6]), .mount_pitch_i(w_in[7]), .mount_yaw_i(w_in[8]),
    .out_valid_o, .out_ready_i,
    .body_vx_o, .body_vy_o, .body_vz_o,
    .mount_roll_rate_o, .mount_pitch_rate_o, .mount_yaw_rate_o
  );

  // drive one word and hold it until accepted
  task automatic send_word(logic [15:0] w[9]);
    in_valid_i <= 1'b1;
    foreach (w[i]) w_in[i] <= w[i];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(w);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 8)) * 4500 - 18000);
      default: return 16'($signed($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      board.check_word('{body_vx_o, body_vy_o, body_vz_o,
                         mount_roll_rate_o, mount_pitch_rate_o, mount_yaw_rate_o});
    if (hold_off) out_ready_i <= 1'b0;
    else if (stim_done) out_ready_i <= 1'b1;
    else out_ready_i <= (($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0));
  end

  initial begin
    logic [15:0] w[9];
    logic [15:0] corner[6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h1000};
    logic [15:0] angs[8] = '{16'd0, 16'd18000, -16'sd18000, 16'd9000, -16'sd9000,
                             16'd4500, 16'h7fff, 16'h8000};
    int burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // corners of the velocity fields against key angles, incl. wrap beyond half turn
    for (int i = 0; i < 24; i++) begin
      foreach (w[j]) w[j] = (j < 6) ? corner[(i + j) % 6] : angs[(i + 3 * j) % 8];
      send_word(w);
    end
    // long receiver hold-off while words keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) begin
        foreach (w[j]) w[j] = (j < 6) ? rand_value() : rand_angle();
        send_word(w);
      end
    join
    idle_cycles(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 1300; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++) begin
        foreach (w[j]) w[j] = (j < 6) ? rand_value() : rand_angle();
        send_word(w);
      end
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
